// ===== rtl/ttb_pkg.sv =====
// ---------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants for the per-triangle tangent/bitangent core.
// ---------------------------------------------------------------------------
package ttb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_LANES       = 6;
    localparam int NUM_DELTAS      = 10;
    localparam int NUM_ACCS        = 7;

    // delta slots
    localparam int D_DU1 = 0;
    localparam int D_DV1 = 1;
    localparam int D_DU2 = 2;
    localparam int D_DV2 = 3;
    localparam int D_E1  = 4;
    localparam int D_E2  = 7;

    // product terms; pairs share an accumulator: even loads, odd subtracts
    typedef enum logic [3:0] {
        TERM_DET_A  = 4'd0,
        TERM_DET_B  = 4'd1,
        TERM_TN_X_A = 4'd2,
        TERM_TN_X_B = 4'd3,
        TERM_TN_Y_A = 4'd4,
        TERM_TN_Y_B = 4'd5,
        TERM_TN_Z_A = 4'd6,
        TERM_TN_Z_B = 4'd7,
        TERM_BN_X_A = 4'd8,
        TERM_BN_X_B = 4'd9,
        TERM_BN_Y_A = 4'd10,
        TERM_BN_Y_B = 4'd11,
        TERM_BN_Z_A = 4'd12,
        TERM_BN_Z_B = 4'd13
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic  hold1;
        logic  hold2;
        logic  capture;
        logic  mul_valid;
        term_t term;
        logic  div_load;
        logic  div_step;
        logic  load_out;
    } ttb_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } ttb_status_t;

endpackage

// ===== rtl/triangle_tangent_bitangent_core.sv =====
// ---------------------------------------------------------------------------
// triangle_tangent_bitangent_core
// Per-triangle tangent and bitangent from three streamed corners.
//
//   channel | dir | payload
//   s_*     | in  | corner: pos_x, pos_y, pos_z, tex_u, tex_v
//   m_*     | out | tangent x/y/z, bitangent x/y/z; tuser = degenerate
//
// Corners one and two are only held. The third corner runs the full sequence
// to a loaded result: 14 products through one shared multiplier, a drain
// state, a divider load, COORD_WIDTH+1 radix-2 steps of six divider lanes
// (skipped on a zero determinant), then the result load, which waits for a
// free output register. Input is held off while a triangle computes.
// A waiting result stalls only the next triangle's final load.
// Reset clears the corner count and held corners.
// ---------------------------------------------------------------------------
module triangle_tangent_bitangent_core #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // degenerate
    output logic                                   m_tuser
);
    import ttb_pkg::*;

    localparam int OUT_W = ((6*COORD_WIDTH+7)/8)*8;

    ttb_cmd_t                cmd;
    ttb_status_t             status;
    logic [6*COORD_WIDTH-1:0] out_data;

    ttb_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ttb_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata[5*COORD_WIDTH-1:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_degen (m_tuser)
    );

    assign m_tdata = OUT_W'(out_data);

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[6*COORD_WIDTH-1:0] == '0)
        else $error("degenerate result with nonzero vectors");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input stalled without an accepted request");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

endmodule

// ===== rtl/ttb_div_lane.sv =====
// ---------------------------------------------------------------------------
// ttb_div_lane
// Radix-2 restoring divider lane: num * 2^FRAC_BITS / den, truncated toward
// zero, saturated to the signed coordinate range. Early overflow check on the
// dividend's high part leaves COORD_WIDTH+1 iteration steps.
// ---------------------------------------------------------------------------
module ttb_div_lane #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic                              step,
    input  logic signed [2*COORD_WIDTH-1:0]   num,
    input  logic signed [2*COORD_WIDTH-1:0]   den,
    output logic        [COORD_WIDTH-1:0]     result
);
    import ttb_pkg::*;

    localparam int RW   = 2 * COORD_WIDTH;
    localparam int DW   = RW + FRAC_BITS;
    localparam int QW   = COORD_WIDTH + 1;
    localparam int HW   = DW - QW;
    localparam int CMPW = (HW > RW) ? HW : RW;

    logic [RW-1:0] n_mag, d_mag;
    logic [DW-1:0] dividend;
    logic [HW-1:0] hi_part;
    logic          ovf;
    logic [RW:0]   rem_shift;
    logic          rem_ge;
    logic [QW-1:0] lim, q_sat, q_signed;

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] d_reg;
    logic [QW-1:0] lo_reg;
    logic [QW-1:0] q_reg;
    logic          neg_reg;
    logic          ovf_reg;

    always_comb
    begin
        n_mag     = num[RW-1] ? RW'(-num) : RW'(num);
        d_mag     = den[RW-1] ? RW'(-den) : RW'(den);
        dividend  = {n_mag, {FRAC_BITS{1'b0}}};
        hi_part   = dividend[DW-1:QW];
        ovf       = CMPW'(hi_part) >= CMPW'(d_mag);
        rem_shift = {rem_reg, lo_reg[QW-1]};
        rem_ge    = rem_shift >= {1'b0, d_reg};
        lim       = QW'({1'b0, {(COORD_WIDTH-1){1'b1}}}) + QW'(neg_reg);
        q_sat     = (ovf_reg || (q_reg > lim)) ? lim : q_reg;
        q_signed  = neg_reg ? QW'(-q_sat) : q_sat;
        result    = q_signed[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= ovf ? '0 : RW'(hi_part);
            d_reg   <= d_mag;
            lo_reg  <= dividend[QW-1:0];
            q_reg   <= '0;
            neg_reg <= num[RW-1] ^ den[RW-1];
            ovf_reg <= ovf;
        end
        else if (step)
        begin
            rem_reg <= rem_ge ? RW'(rem_shift - {1'b0, d_reg}) : rem_shift[RW-1:0];
            lo_reg  <= {lo_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], rem_ge};
        end
    end

endmodule

// ===== rtl/ttb_datapath.sv =====
// ---------------------------------------------------------------------------
// ttb_datapath
// Corner hold registers, saturated deltas, shared multiplier with product
// accumulators, six divider lanes and the result register.
// ---------------------------------------------------------------------------
module ttb_datapath #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttb_pkg::ttb_cmd_t             cmd,
    output ttb_pkg::ttb_status_t          status,
    input  logic [5*COORD_WIDTH-1:0]      in_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [6*COORD_WIDTH-1:0]      out_data,
    output logic                          out_degen
);
    import ttb_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int RW = 2 * COORD_WIDTH;

    logic signed [CW-1:0] in_f   [5];
    logic signed [CW-1:0] mnd    [NUM_DELTAS];
    logic signed [CW-1:0] sbt    [NUM_DELTAS];
    logic signed [CW-1:0] dlt    [NUM_DELTAS];
    logic signed [CW-1:0] op_a, op_b;
    logic                 det_zero;
    logic [CW-1:0]        lane_res [NUM_LANES];

    logic signed [CW-1:0] held_pos_reg [6];
    logic signed [CW-1:0] held_tex_reg [4];
    logic signed [CW-1:0] delta_reg    [NUM_DELTAS];
    logic signed [RW-1:0] prod_reg;
    logic                 prod_valid_reg;
    term_t                term_d_reg;
    logic signed [RW-1:0] acc_reg      [NUM_ACCS];
    logic [6*CW-1:0]      out_data_reg;
    logic                 out_degen_reg;
    logic                 out_valid_reg;

    always_comb
    begin
        logic [CW:0] diff;
        for (int k = 0; k < 5; k++)
            in_f[k] = in_data[k*CW +: CW];
        mnd[D_DU1] = held_tex_reg[2]; sbt[D_DU1] = held_tex_reg[0];
        mnd[D_DV1] = held_tex_reg[3]; sbt[D_DV1] = held_tex_reg[1];
        mnd[D_DU2] = in_f[3];         sbt[D_DU2] = held_tex_reg[0];
        mnd[D_DV2] = in_f[4];         sbt[D_DV2] = held_tex_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            mnd[D_E1+i] = held_pos_reg[3+i]; sbt[D_E1+i] = held_pos_reg[i];
            mnd[D_E2+i] = in_f[i];           sbt[D_E2+i] = held_pos_reg[i];
        end
        for (int i = 0; i < NUM_DELTAS; i++)
        begin
            diff = {mnd[i][CW-1], mnd[i]} - {sbt[i][CW-1], sbt[i]};
            if (diff[CW] != diff[CW-1])
                dlt[i] = diff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            else
                dlt[i] = diff[CW-1:0];
        end
    end

    always_comb
    begin
        case (cmd.term)
            TERM_DET_A:  begin op_a = delta_reg[D_DU1]; op_b = delta_reg[D_DV2];  end
            TERM_DET_B:  begin op_a = delta_reg[D_DU2]; op_b = delta_reg[D_DV1];  end
            TERM_TN_X_A: begin op_a = delta_reg[D_DV2]; op_b = delta_reg[D_E1];   end
            TERM_TN_X_B: begin op_a = delta_reg[D_DV1]; op_b = delta_reg[D_E2];   end
            TERM_TN_Y_A: begin op_a = delta_reg[D_DV2]; op_b = delta_reg[D_E1+1]; end
            TERM_TN_Y_B: begin op_a = delta_reg[D_DV1]; op_b = delta_reg[D_E2+1]; end
            TERM_TN_Z_A: begin op_a = delta_reg[D_DV2]; op_b = delta_reg[D_E1+2]; end
            TERM_TN_Z_B: begin op_a = delta_reg[D_DV1]; op_b = delta_reg[D_E2+2]; end
            TERM_BN_X_A: begin op_a = delta_reg[D_DU1]; op_b = delta_reg[D_E2];   end
            TERM_BN_X_B: begin op_a = delta_reg[D_DU2]; op_b = delta_reg[D_E1];   end
            TERM_BN_Y_A: begin op_a = delta_reg[D_DU1]; op_b = delta_reg[D_E2+1]; end
            TERM_BN_Y_B: begin op_a = delta_reg[D_DU2]; op_b = delta_reg[D_E1+1]; end
            TERM_BN_Z_A: begin op_a = delta_reg[D_DU1]; op_b = delta_reg[D_E2+2]; end
            TERM_BN_Z_B: begin op_a = delta_reg[D_DU2]; op_b = delta_reg[D_E1+2]; end
            default:     begin op_a = '0;               op_b = '0;                end
        endcase
    end

    // holds reset to zero, matching the empty-triangle start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++) held_pos_reg[i] <= '0;
            for (int i = 0; i < 4; i++) held_tex_reg[i] <= '0;
        end
        else if (cmd.hold1)
        begin
            for (int i = 0; i < 3; i++) held_pos_reg[i] <= in_f[i];
            held_tex_reg[0] <= in_f[3];
            held_tex_reg[1] <= in_f[4];
        end
        else if (cmd.hold2)
        begin
            for (int i = 0; i < 3; i++) held_pos_reg[3+i] <= in_f[i];
            held_tex_reg[2] <= in_f[3];
            held_tex_reg[3] <= in_f[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            for (int i = 0; i < NUM_DELTAS; i++) delta_reg[i] <= dlt[i];
        prod_reg   <= op_a * op_b;
        term_d_reg <= cmd.term;
        if (prod_valid_reg)
        begin
            if (term_d_reg[0])
                acc_reg[term_d_reg[3:1]] <= acc_reg[term_d_reg[3:1]] - prod_reg;
            else
                acc_reg[term_d_reg[3:1]] <= prod_reg;
        end
        if (cmd.load_out)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                out_data_reg[i*CW +: CW] <= det_zero ? '0 : lane_res[i];
            out_degen_reg <= det_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.mul_valid;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        ttb_div_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .load   (cmd.div_load),
            .step   (cmd.div_step),
            .num    (acc_reg[g+1]),
            .den    (acc_reg[0]),
            .result (lane_res[g])
        );
    end

    assign det_zero        = (acc_reg[0] == '0);
    assign status.det_zero = det_zero;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_degen       = out_degen_reg;

endmodule

// ===== rtl/ttb_ctrl.sv =====
// ---------------------------------------------------------------------------
// ttb_ctrl
// Sequencer: corner counting, product term issue, divider steps, result load.
// ---------------------------------------------------------------------------
module ttb_ctrl #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ttb_pkg::ttb_status_t status,
    output ttb_pkg::ttb_cmd_t    cmd
);
    import ttb_pkg::*;

    localparam int DCW = $clog2(COORD_WIDTH + 2);

    ctrl_state_t    state_reg, state_next;
    logic [1:0]     corner_reg, corner_next;
    term_t          term_reg, term_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            corner_reg  <= '0;
            term_reg    <= TERM_DET_A;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            corner_reg  <= corner_next;
            term_reg    <= term_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        corner_next   = corner_reg;
        term_next     = term_reg;
        div_cnt_next  = div_cnt_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.term      = term_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (corner_reg)
                        2'd1:
                        begin
                            cmd.hold2   = 1'b1;
                            corner_next = 2'd2;
                        end
                        2'd2:
                        begin
                            cmd.capture = 1'b1;
                            corner_next = 2'd0;
                            term_next   = TERM_DET_A;
                            state_next  = ST_MUL;
                        end
                        default:
                        begin
                            cmd.hold1   = 1'b1;
                            corner_next = 2'd1;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul_valid = 1'b1;
                if (term_reg == TERM_BN_Z_B)
                    state_next = ST_DRAIN;
                else
                    term_next = term_t'(4'(term_reg + 4'd1));
            end
            ST_DRAIN:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                cmd.div_load = 1'b1;
                div_cnt_next = '0;
                state_next   = status.det_zero ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = DCW'(div_cnt_reg + 1'b1);
                if (div_cnt_reg == DCW'(COORD_WIDTH))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== bench/tb_triangle_tangent_bitangent_core.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_tangent_bitangent_core
// Self-checking bench for the per-triangle tangent/bitangent core.
//
// Corners stream in over the slave channel in groups of three. A local
// fixed-point model holds the first two corners and, on the third, works out
// the tangent, the bitangent and the degenerate flag. Each result request on
// the master channel is checked field by field against the oldest prediction.
// Directed triangles cover the plain case, zero determinant, saturated deltas,
// saturated quotients and bit patterns. A long random mix with idle gaps on
// both channels follows, then a back-to-back stretch with no gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_tangent_bitangent_core;

    localparam int CW          = ttb_pkg::COORD_WIDTH_DEF;
    localparam int FB          = ttb_pkg::FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = CW + 18 + 100;
    localparam int RANDOM_TRIS = 480;
    localparam int BURST_TRIS  = 100;
    localparam int PRINT_CAP   = 40;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE   = 1 <<< FB;

    typedef struct packed {
        logic signed [CW-1:0] tex_v;
        logic signed [CW-1:0] tex_u;
        logic signed [CW-1:0] pos_z;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] pos_x;
    } corner_t;

    typedef struct packed {
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] tz;
        logic signed [CW-1:0] ty;
        logic signed [CW-1:0] tx;
    } basis_t;

    typedef struct packed {
        basis_t vec;
        logic   degenerate;
    } frame_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [5*CW-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [6*CW-1:0]      m_tdata;
    logic                 m_tuser;

    logic                 idle_en  = 1'b1;
    int unsigned          cycle_count;
    int unsigned          error_count;
    int unsigned          corners_sent;
    int unsigned          frames_seen;
    int unsigned          degenerate_seen;

    // model state
    logic signed [CW-1:0] held_pos [6];
    logic signed [CW-1:0] held_tex [4];
    int unsigned          corner_idx;
    frame_t               pending_frames [$];

    triangle_tangent_bitangent_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_frames.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!idle_en)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 12);
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        error_count++;
    endtask

    // delta of two coordinates, saturated to the coordinate range
    function automatic logic signed [63:0] sat_delta(logic signed [CW-1:0] a,
                                                     logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        if (d[CW] != d[CW-1])
            return 64'(d[CW] ? C_MIN : C_MAX);
        return 64'(signed'(d[CW-1:0]));
    endfunction

    // num * 2^FB / den, truncated toward zero, saturated
    function automatic logic [CW-1:0] scaled_quotient(logic signed [63:0] num,
                                                      logic signed [63:0] den);
        logic [63:0]    n_abs;
        logic [63:0]    d_abs;
        logic [64+FB:0] q;
        logic [64+FB:0] lim;
        logic           neg;
        n_abs = num[63] ? -num : num;
        d_abs = den[63] ? -den : den;
        neg   = num[63] ^ den[63];
        q     = {1'b0, n_abs, {FB{1'b0}}} / {{(FB+1){1'b0}}, d_abs};
        lim   = {{(FB+1){1'b0}}, 64'd1} << (CW-1);
        if (!neg)
            lim = lim - 1'b1;
        if (q > lim)
            q = lim;
        return neg ? CW'(-q) : q[CW-1:0];
    endfunction

    function automatic void predict_tangent_frame(corner_t c);
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] du1, dv1, du2, dv2, det, tn, bn;
        logic signed [CW-1:0] p [3];
        frame_t f;
        p[0] = c.pos_x;
        p[1] = c.pos_y;
        p[2] = c.pos_z;
        case (corner_idx)
            1:
            begin
                for (int i = 0; i < 3; i++)
                    held_pos[3+i] = p[i];
                held_tex[2] = c.tex_u;
                held_tex[3] = c.tex_v;
                corner_idx  = 2;
            end
            2:
            begin
                corner_idx = 0;
                for (int i = 0; i < 3; i++)
                begin
                    e1[i] = sat_delta(held_pos[3+i], held_pos[i]);
                    e2[i] = sat_delta(p[i], held_pos[i]);
                end
                du1 = sat_delta(held_tex[2], held_tex[0]);
                dv1 = sat_delta(held_tex[3], held_tex[1]);
                du2 = sat_delta(c.tex_u, held_tex[0]);
                dv2 = sat_delta(c.tex_v, held_tex[1]);
                det = du1 * dv2 - du2 * dv1;
                f   = '0;
                if (det == 0)
                    f.degenerate = 1'b1;
                else
                begin
                    tn = dv2 * e1[0] - dv1 * e2[0];
                    bn = du1 * e2[0] - du2 * e1[0];
                    f.vec.tx = scaled_quotient(tn, det);
                    f.vec.bx = scaled_quotient(bn, det);
                    tn = dv2 * e1[1] - dv1 * e2[1];
                    bn = du1 * e2[1] - du2 * e1[1];
                    f.vec.ty = scaled_quotient(tn, det);
                    f.vec.by = scaled_quotient(bn, det);
                    tn = dv2 * e1[2] - dv1 * e2[2];
                    bn = du1 * e2[2] - du2 * e1[2];
                    f.vec.tz = scaled_quotient(tn, det);
                    f.vec.bz = scaled_quotient(bn, det);
                end
                pending_frames = {pending_frames, f};
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    held_pos[i] = p[i];
                held_tex[0] = c.tex_u;
                held_tex[1] = c.tex_v;
                corner_idx  = 1;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [CW-1:0] got,
                               input logic [CW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("frame %0d %s: got %h expected %h",
                                      frames_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin
        basis_t got;
        frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_frames.size() == 0)
                report_mismatch($sformatf("unexpected result %h user %b",
                                          m_tdata, m_tuser));
            else
            begin
                want = pending_frames.pop_front();
                check_field("tangent_x", got.tx, want.vec.tx);
                check_field("tangent_y", got.ty, want.vec.ty);
                check_field("tangent_z", got.tz, want.vec.tz);
                check_field("bitangent_x", got.bx, want.vec.bx);
                check_field("bitangent_y", got.by, want.vec.by);
                check_field("bitangent_z", got.bz, want.vec.bz);
                check_field("degenerate", CW'(m_tuser), CW'(want.degenerate));
                if (want.degenerate)
                    degenerate_seen++;
            end
            frames_seen++;
        end
    end

    // one corner request; valid stays up across back-to-back requests
    task automatic push_corner(input corner_t c);
        if (idle_en && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tangent_frame(c);
        corners_sent++;
    endtask

    function automatic corner_t mk(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                   logic signed [CW-1:0] pz, logic signed [CW-1:0] u,
                                   logic signed [CW-1:0] v);
        return {v, u, pz, py, px};
    endfunction

    function automatic logic signed [CW-1:0] small_coord();
        logic signed [CW-1:0] r;
        r = $urandom_range(0, 32'h000f_ffff);
        return r - 32'sh0008_0000;
    endfunction

    function automatic logic signed [CW-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_basic_triangle();
        push_corner(mk(0, 0, 0, 0, 0));
        push_corner(mk(ONE, 0, 0, ONE, 0));
        push_corner(mk(0, ONE, 0, 0, ONE));
        push_corner(mk(3 * ONE, -ONE, ONE / 2, ONE / 4, -ONE));
        push_corner(mk(-2 * ONE, 5 * ONE, 0, 2 * ONE, ONE / 2));
        push_corner(mk(ONE, ONE, -7 * ONE, -ONE, 3 * ONE));
    endtask

    task automatic test_zero_determinant();
        push_corner(mk(0, 0, 0, ONE / 2, ONE / 2));
        push_corner(mk(ONE, 2 * ONE, 0, ONE / 2, ONE / 2));
        push_corner(mk(0, ONE, 3 * ONE, ONE / 2, ONE / 2));
        // collinear texture coordinates
        push_corner(mk(ONE, 0, 0, 0, 0));
        push_corner(mk(0, ONE, 0, ONE, 2 * ONE));
        push_corner(mk(0, 0, ONE, 2 * ONE, 4 * ONE));
    endtask

    task automatic test_delta_saturation();
        push_corner(mk(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX));
        push_corner(mk(C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
        push_corner(mk(C_MAX, C_MIN, 0, C_MAX, C_MAX));
    endtask

    task automatic test_quotient_saturation();
        push_corner(mk(0, 0, 0, 0, 0));
        push_corner(mk(C_MAX, C_MIN, ONE, 1, 0));
        push_corner(mk(C_MIN, C_MAX, -ONE, 0, 1));
        push_corner(mk(0, 0, 0, 0, 0));
        push_corner(mk(C_MAX, C_MAX, C_MIN, 0, 1));
        push_corner(mk(C_MAX, C_MIN, C_MAX, 1, 0));
    endtask

    task automatic test_bit_patterns();
        push_corner(mk(-1, -1, -1, -1, -1));
        push_corner(mk(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                       32'haaaa_aaaa, 32'h5555_5555));
        push_corner(mk(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                       32'h5555_5555, 32'haaaa_aaaa));
    endtask

    task automatic send_random_triangle();
        corner_t     c [3];
        int unsigned style;
        int          k;
        logic signed [CW-1:0] base_u, base_v;
        style  = $urandom_range(0, 99);
        k      = $urandom_range(0, 3) - 1;
        base_u = $urandom;
        base_v = $urandom;
        for (int i = 0; i < 3; i++)
        begin
            if (style < 30)
                c[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
            else if (style < 65)
                c[i] = mk(small_coord(), small_coord(), small_coord(),
                          small_coord(), small_coord());
            else if (style < 75)
                c[i] = mk(pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme());
            else if (style < 85)
                c[i] = mk(small_coord(), small_coord(), small_coord(),
                          small_coord(), small_coord());
            else
                c[i] = mk($urandom, $urandom, $urandom,
                          base_u + $urandom_range(0, 3), base_v + $urandom_range(0, 3));
        end
        // collinear texture coordinates give a zero determinant
        if (style >= 75 && style < 85)
        begin
            c[2].tex_u = c[0].tex_u + k * (c[1].tex_u - c[0].tex_u);
            c[2].tex_v = c[0].tex_v + k * (c[1].tex_v - c[0].tex_v);
        end
        for (int i = 0; i < 3; i++)
            push_corner(c[i]);
    endtask

    task automatic test_random_mix();
        idle_en <= 1'b1;
        repeat (RANDOM_TRIS)
            send_random_triangle();
    endtask

    task automatic test_back_to_back();
        idle_en <= 1'b0;
        repeat (BURST_TRIS)
            send_random_triangle();
        idle_en <= 1'b1;
    endtask

    initial
    begin
        corner_idx = 0;
        for (int i = 0; i < 6; i++)
            held_pos[i] = '0;
        for (int i = 0; i < 4; i++)
            held_tex[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_triangle();
        test_zero_determinant();
        test_delta_saturation();
        test_quotient_saturation();
        test_bit_patterns();
        test_random_mix();
        test_back_to_back();

        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_frames.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_frames.size()));
        $display("Sent %0d corners; checked %0d triangle results, %0d of them degenerate,",
                 corners_sent, frames_seen, degenerate_seen);
        $display("with random gaps on both channels and a gap-free burst; %0d mismatches",
                 error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
